// ----- rtl/core/fbma_pkg.sv -----
// Package for the frame bitmap allocator: item types, status codes and the
// command and status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbma_pkg;

  localparam int unsigned FRAME_W           = 12;
  localparam int unsigned COUNT_W           = 13;
  localparam int unsigned FRAME_FIELD_LIMIT = 4096;
  localparam int unsigned COUNT_RESET       = 4096;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_MAPPED    = 3'd1,
    ST_FREED     = 3'd2,
    ST_NOTHING   = 3'd3,
    ST_OUT       = 3'd4
  } status_e;

  typedef struct packed {
    logic               action;
    logic [FRAME_W-1:0] current_frame;
    logic               is_kernel;
    logic               is_writeable;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [FRAME_W-1:0] frame_number;
    logic               present;
    logic               writable;
    logic               user_access;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SCAN,
    OP_DIV,
    OP_FRD,
    OP_FWR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_free;
    logic in_zero;
    logic scan_found;
    logic scan_empty;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/fbma_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fbma_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fbma_ctrl.sv -----
// Controller of the frame bitmap allocator: sequences the clearing pass,
// the first-fit scan, the free path and result delivery. Uses fbma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbma_ctrl
  import fbma_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output      logic    in_stall_o,
  input  wire dp_sts_t sts_i,
  output      dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_FRD,
    S_FWR,
    S_DELIVER
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o.op       = OP_NONE;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (sts_i.in_free) begin
            state_d = sts_i.in_zero ? S_DELIVER : S_DIV;
          end else begin
            state_d = sts_i.in_zero ? S_SCAN : S_DELIVER;
          end
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (sts_i.scan_found || sts_i.scan_empty) begin
          state_d = S_DELIVER;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        state_d  = S_FRD;
      end
      S_FRD: begin
        cmd_o.op = OP_FRD;
        state_d  = S_FWR;
      end
      S_FWR: begin
        cmd_o.op = OP_FWR;
        state_d  = S_DELIVER;
      end
      S_DELIVER: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fbma_datapath.sv -----
// Datapath of the frame bitmap allocator: bitmap RAM, scan counters, word
// priority encoder, free-path address split, result and output registers.
// Uses fbma_pkg and fbma_ram.
`timescale 1ns / 1ps
`default_nettype none

module fbma_datapath
  import fbma_pkg::*;
#(
  parameter int unsigned MAX_FRAMES       = 4096,
  parameter int unsigned BITMAP_WORD_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire in_item_t           in_item_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [COUNT_W-1:0] cfg_data_i,
  input  wire logic               out_stall_i,
  output      logic               out_valid_o,
  output      out_item_t          out_item_o,
  input  wire dp_cmd_t            cmd_i,
  output      dp_sts_t            sts_o
);

  localparam int unsigned WB          = BITMAP_WORD_BITS;
  localparam int unsigned FRAME_LIMIT =
    (MAX_FRAMES < FRAME_FIELD_LIMIT) ? MAX_FRAMES : FRAME_FIELD_LIMIT;
  localparam int unsigned DEPTH       = (FRAME_LIMIT + WB - 1) / WB;
  localparam int unsigned ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned BIT_W       = $clog2(WB);
  localparam int unsigned BASE_W      = COUNT_W + 1;
  localparam int unsigned DIV_SHIFT   = 20;
  localparam int unsigned RECIP       = ((1 << DIV_SHIFT) + WB - 1) / WB;

  logic [COUNT_W-1:0] frame_count_q;
  logic [CNT_W-1:0]   addr_q;
  logic [BASE_W-1:0]  base_q, chk_base_q, lim_q;
  logic [ADDR_W-1:0]  chk_addr_q;
  logic               chk_vld_q;
  logic               out_valid_q;
  in_item_t           item_q;
  out_item_t          res_q, out_q;
  logic [FRAME_W-1:0] quot_q;
  logic [BIT_W-1:0]   bit_q;

  logic               rd_en, wr_en;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [WB-1:0]      rd_data, wr_data;
  logic [WB-1:0]      free_vec, found_mask, bit_mask;
  logic [BIT_W-1:0]   idx;
  logic               any_free, found, empty, in_range;
  logic [BASE_W-1:0]  rem, lim_new, found_frame;
  logic [31:0]        div_prod;
  logic [17:0]        mul_back, bit_diff;

  fbma_ram #(
    .WIDTH (WB),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign rem = lim_q - chk_base_q;

  always_comb begin
    for (int unsigned b = 0; b < WB; b++) begin
      free_vec[b] = !rd_data[b] && (BASE_W'(b) < rem);
    end
  end

  always_comb begin
    idx = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        idx = BIT_W'(b);
      end
    end
  end

  assign any_free    = |free_vec;
  assign found       = chk_vld_q && any_free;
  assign empty       = chk_vld_q ? (!any_free && (rem <= BASE_W'(WB))) : (base_q >= lim_q);
  assign found_frame = chk_base_q + BASE_W'(idx);
  assign found_mask  = WB'(1) << idx;
  assign bit_mask    = WB'(1) << bit_q;
  assign in_range    = {1'b0, item_q.current_frame} < COUNT_W'(FRAME_LIMIT);
  assign lim_new     = ({1'b0, frame_count_q} > BASE_W'(FRAME_LIMIT)) ?
                       BASE_W'(FRAME_LIMIT) : {1'b0, frame_count_q};
  assign div_prod    = 32'(item_q.current_frame) * 32'(RECIP);
  assign mul_back    = 18'(quot_q) * 18'(WB);
  assign bit_diff    = 18'(item_q.current_frame) - mul_back;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr_q[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = addr_q[ADDR_W-1:0];
    wr_data = '0;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        wr_en = 1'b1;
      end
      OP_SCAN: begin
        rd_en   = base_q < lim_q;
        wr_en   = found;
        wr_addr = chk_addr_q;
        wr_data = rd_data | found_mask;
      end
      OP_FRD: begin
        rd_en   = in_range;
        rd_addr = ADDR_W'(quot_q);
      end
      OP_FWR: begin
        wr_en   = in_range;
        wr_addr = ADDR_W'(quot_q);
        wr_data = rd_data & ~bit_mask;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= COUNT_W'(COUNT_RESET);
      addr_q        <= '0;
      base_q        <= '0;
      chk_base_q    <= '0;
      chk_addr_q    <= '0;
      lim_q         <= '0;
      chk_vld_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        frame_count_q <= cfg_data_i;
      end
      unique case (cmd_i.op)
        OP_CLEAR: begin
          addr_q <= addr_q + CNT_W'(1);
        end
        OP_LOAD: begin
          addr_q    <= '0;
          base_q    <= '0;
          chk_vld_q <= 1'b0;
          lim_q     <= lim_new;
        end
        OP_SCAN: begin
          chk_vld_q  <= rd_en;
          chk_base_q <= base_q;
          chk_addr_q <= addr_q[ADDR_W-1:0];
          if (rd_en) begin
            addr_q <= addr_q + CNT_W'(1);
            base_q <= base_q + BASE_W'(WB);
          end
        end
        default: begin
        end
      endcase
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        item_q             <= in_item_i;
        res_q.status       <= (in_item_i.action == ACT_FREE) ? ST_NOTHING : ST_MAPPED;
        res_q.frame_number <= (in_item_i.action == ACT_FREE) ? '0 : in_item_i.current_frame;
        res_q.present      <= 1'b0;
        res_q.writable     <= 1'b0;
        res_q.user_access  <= 1'b0;
      end
      OP_SCAN: begin
        if (found) begin
          res_q.status       <= ST_ALLOCATED;
          res_q.frame_number <= FRAME_W'(found_frame);
          res_q.present      <= 1'b1;
          res_q.writable     <= item_q.is_writeable;
          res_q.user_access  <= !item_q.is_kernel;
        end else if (empty) begin
          res_q.status       <= ST_OUT;
          res_q.frame_number <= '0;
        end
      end
      OP_DIV: begin
        quot_q <= div_prod[DIV_SHIFT +: FRAME_W];
      end
      OP_FRD: begin
        bit_q <= bit_diff[BIT_W-1:0];
      end
      OP_FWR: begin
        res_q.status       <= ST_FREED;
        res_q.frame_number <= '0;
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;
  assign sts_o.clr_last    = (addr_q == CNT_W'(DEPTH - 1));
  assign sts_o.in_free     = (in_item_i.action == ACT_FREE);
  assign sts_o.in_zero     = (in_item_i.current_frame == '0);
  assign sts_o.scan_found  = found;
  assign sts_o.scan_empty  = empty;
  assign sts_o.out_busy    = out_valid_q && out_stall_i;

  a_found_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found |-> (found_frame < lim_q))
    else $error("allocated frame lies beyond the frame limit");

  a_alloc_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_ALLOCATED) |-> out_q.present)
    else $error("allocated item without present bit");

  a_other_flags_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_ALLOCATED) |->
      !(out_q.present || out_q.writable || out_q.user_access))
    else $error("page entry bits set on an item that allocated nothing");

endmodule

`default_nettype wire

// ----- rtl/core/frame_bitmap_allocator_unit.sv -----
// Top level of the first-fit physical frame bitmap allocator.
// Uses fbma_pkg, fbma_ctrl and fbma_datapath.
//
// Channel  Direction  Handshake           Payload
// in       input      in_valid_i/stall_o  in_item_i  (in_item_t)
// out      output     out_valid_o/stall_i out_item_o (out_item_t)
// cfg      input      cfg_valid_i/ready_o cfg_data_i (frame_count)
//
// After reset the bitmap RAM is cleared one word a cycle, all
// ceil(min(MAX_FRAMES, 4096) / BITMAP_WORD_BITS) words of it (128 by default);
// no item is accepted meanwhile. An allocation scans the words in order and stops at
// the first one with a free bit below the limit, or reports none free once past it,
// limit being min(frame_count, MAX_FRAMES, 4096).
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none

module frame_bitmap_allocator_unit
  import fbma_pkg::*;
#(
  parameter int unsigned MAX_FRAMES       = 4096,
  parameter int unsigned BITMAP_WORD_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire in_item_t           in_item_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      out_item_t          out_item_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [COUNT_W-1:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  fbma_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  fbma_datapath #(
    .MAX_FRAMES      (MAX_FRAMES),
    .BITMAP_WORD_BITS(BITMAP_WORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire
